// File: design/pcpc_pkg.sv
// shared types, widths and constants of the pie chart pixel classifier
// no dependencies; imported by the core, the cordic pipeline and the checker
package pcpc_pkg;

   // field widths
   localparam int PIX_W       = 10;
   localparam int WEIGHT_W    = 16;
   localparam int RADIUS_W    = 9;
   localparam int BORDER_W    = 6;
   localparam int COLOR_W     = 8;
   localparam int REGION_W    = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // geometry widths: doubled offsets, their squares and the radius squares
   localparam int OFS_W   = 12;
   localparam int SQ_W    = 22;
   localparam int DIST_W  = 23;
   localparam int RSQ_W   = 21;
   localparam int RING_W  = 11;
   localparam int TOTAL_W = 18;

   // cordic datapath
   localparam int VEC_W        = 36;
   localparam int TURN_W       = 32;
   localparam int PRE_SHIFT    = 20;
   localparam int CORDIC_STEPS = 24;
   localparam logic [TURN_W-1:0] HALF_TURN_Z = {1'b1, {(TURN_W-1){1'b0}}};

   // atan(2^-i) as a fraction of a turn, scaled by 2^32
   localparam logic [TURN_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // transfer to result: input register, pre-rotation, cordic steps, multiply, classify
   localparam int LATENCY = CORDIC_STEPS + 4;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_RED   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_GREEN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_BLUE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_RADIUS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BORDER_WIDTH = 3'd4;

   localparam logic [COLOR_W-1:0] COLOR_ON  = 8'hFF;
   localparam logic [COLOR_W-1:0] COLOR_OFF = 8'h00;

   typedef enum logic [REGION_W-1:0] {
      REGION_RED     = 3'd0,
      REGION_GREEN   = 3'd1,
      REGION_BLUE    = 3'd2,
      REGION_BLANK   = 3'd3,
      REGION_BORDER  = 3'd4,
      REGION_OUTSIDE = 3'd5
   } region_type;

   // per-pixel flags that travel beside the cordic vector
   typedef struct packed {
      logic centre;
      logic in_disc;
      logic in_ring;
   } pcpc_tag_type;

endpackage

// File: design/pie_chart_pixel_classifier_core.sv
// channel   ports                        transfer
// -------   --------------------------   -------------------------------------
// request   start, busy, req_pix_*       edge with start high and busy low
// result    rsp_valid, rsp_*             one-cycle strobe, always taken
// config    csr_we, csr_index, csr_wdata edge with csr_we high, no wait
//
// one pixel per clock; busy is never raised
// a result passes the input and pre-rotation registers, the 24 stages of the cordic
// pipeline, then the slice multiply and classify registers
// synchronous reset clears the stage valid bits and restores the registers
// derived thresholds are registered from the registers and follow them in the cycle after they change
//
// top level of the pie chart pixel classifier; uses pcpc_pkg and pcpc_cordic
module pie_chart_pixel_classifier_core import pcpc_pkg::*; #(
   parameter int IMAGE_SIZE = 100,
   parameter int ANGLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [PIX_W-1:0]       req_pix_x,
   input  logic [PIX_W-1:0]       req_pix_y,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   rsp_valid,
   output logic [COLOR_W-1:0]     rsp_out_red,
   output logic [COLOR_W-1:0]     rsp_out_green,
   output logic [COLOR_W-1:0]     rsp_out_blue,
   output logic [REGION_W-1:0]    rsp_region,
   output logic                   rsp_invalid
);

   localparam int AT_W = ANGLE_BITS + TOTAL_W;
   localparam logic signed [OFS_W-1:0] CENTER_OFS = OFS_W'(IMAGE_SIZE - 1);
   localparam logic [ANGLE_BITS-1:0] HALF_ANGLE = {1'b1, {(ANGLE_BITS-1){1'b0}}};
   localparam logic [ANGLE_BITS-1:0] MIN_ANGLE  = {{(ANGLE_BITS-1){1'b0}}, 1'b1};

   // configuration registers
   logic [WEIGHT_W-1:0] weight_red_ff, weight_green_ff, weight_blue_ff;
   logic [RADIUS_W-1:0] inner_radius_ff;
   logic [BORDER_W-1:0] border_width_ff;

   // thresholds derived from the registers
   logic [TOTAL_W-1:0] total_ff;
   logic [AT_W-1:0]    cut_r_ff, cut_g_ff;
   logic [RSQ_W-1:0]   r2sq_ff, b2sq_ff;
   logic [RING_W-1:0]  ring_in;

   // input stage
   logic                    valid_a_ff;
   logic signed [OFS_W-1:0] dx_a_ff, dy_a_ff;

   // pre-rotation stage
   logic                    valid_b_ff, centre_b_ff;
   logic signed [VEC_W-1:0] x_b_ff, y_b_ff, x_b_in, y_b_in;
   logic [TURN_W-1:0]       z_b_ff, z_b_in;
   logic [SQ_W-1:0]         dxsq_b_ff, dysq_b_ff;
   logic signed [VEC_W-1:0] dx_ext, dy_ext;
   logic signed [2*OFS_W-1:0] dxsq_full, dysq_full;
   logic [DIST_W-1:0]       dist_sq;
   pcpc_tag_type            tag_b;

   // cordic output
   logic          valid_c;
   logic [TURN_W-1:0] z_c;
   pcpc_tag_type  tag_c;

   // slice multiply stage
   logic                  valid_d_ff;
   logic [AT_W-1:0]       at_d_ff;
   pcpc_tag_type          tag_d_ff;
   logic [ANGLE_BITS-1:0] angle_raw, angle_c;

   // classify stage
   logic               rsp_valid_ff;
   logic [COLOR_W-1:0] red_ff, green_ff, blue_ff, red_in, green_in, blue_in;
   region_type         region_ff, region_in;
   logic               invalid_ff;

   assign busy = 1'b0;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_red_ff   <= WEIGHT_W'(1);
         weight_green_ff <= WEIGHT_W'(1);
         weight_blue_ff  <= WEIGHT_W'(1);
         inner_radius_ff <= RADIUS_W'(45);
         border_width_ff <= BORDER_W'(3);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WEIGHT_RED:   weight_red_ff   <= csr_wdata[WEIGHT_W-1:0];
            CSR_WEIGHT_GREEN: weight_green_ff <= csr_wdata[WEIGHT_W-1:0];
            CSR_WEIGHT_BLUE:  weight_blue_ff  <= csr_wdata[WEIGHT_W-1:0];
            CSR_INNER_RADIUS: inner_radius_ff <= csr_wdata[RADIUS_W-1:0];
            CSR_BORDER_WIDTH: border_width_ff <= csr_wdata[BORDER_W-1:0];
            default: ;
         endcase
      end
   end

   // weight sums, slice cuts and doubled radius squares
   assign ring_in = RING_W'(inner_radius_ff) + RING_W'(border_width_ff);

   always_ff @(posedge clock) begin
      total_ff <= TOTAL_W'(weight_red_ff) + TOTAL_W'(weight_green_ff)
                + TOTAL_W'(weight_blue_ff);
      cut_r_ff <= AT_W'(weight_red_ff) << ANGLE_BITS;
      cut_g_ff <= (AT_W'(weight_red_ff) + AT_W'(weight_green_ff)) << ANGLE_BITS;
      r2sq_ff  <= RSQ_W'({inner_radius_ff, 1'b0}) * RSQ_W'({inner_radius_ff, 1'b0});
      b2sq_ff  <= RSQ_W'({ring_in, 1'b0}) * RSQ_W'({ring_in, 1'b0});
   end

   // input stage: doubled offsets from the image centre
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      dx_a_ff <= $signed({1'b0, req_pix_x, 1'b0}) - CENTER_OFS;
      dy_a_ff <= $signed({1'b0, req_pix_y, 1'b0}) - CENTER_OFS;
   end

   // pre-rotation: point at (-dx,-dy), fold the left half plane by half a turn
   assign dx_ext    = VEC_W'(dx_a_ff);
   assign dy_ext    = VEC_W'(dy_a_ff);
   assign dxsq_full = dx_a_ff * dx_a_ff;
   assign dysq_full = dy_a_ff * dy_a_ff;

   always_comb begin
      if (dx_a_ff > 0) begin
         x_b_in = dx_ext <<< PRE_SHIFT;
         y_b_in = dy_ext <<< PRE_SHIFT;
         z_b_in = HALF_TURN_Z;
      end else begin
         x_b_in = (-dx_ext) <<< PRE_SHIFT;
         y_b_in = (-dy_ext) <<< PRE_SHIFT;
         z_b_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_b_ff      <= x_b_in;
      y_b_ff      <= y_b_in;
      z_b_ff      <= z_b_in;
      dxsq_b_ff   <= dxsq_full[SQ_W-1:0];
      dysq_b_ff   <= dysq_full[SQ_W-1:0];
      centre_b_ff <= (dx_a_ff == '0) && (dy_a_ff == '0);
   end

   // disc and ring tests ride beside the vector
   assign dist_sq       = DIST_W'(dxsq_b_ff) + DIST_W'(dysq_b_ff);
   assign tag_b.centre  = centre_b_ff;
   assign tag_b.in_disc = dist_sq <= DIST_W'(r2sq_ff);
   assign tag_b.in_ring = dist_sq <= DIST_W'(b2sq_ff);

   pcpc_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_b_ff),
      .in_x      (x_b_ff),
      .in_y      (y_b_ff),
      .in_z      (z_b_ff),
      .in_tag    (tag_b),
      .out_valid (valid_c),
      .out_z     (z_c),
      .out_tag   (tag_c)
   );

   // truncate the turn fraction, fix up zero and the exact centre
   assign angle_raw = z_c[TURN_W-1 -: ANGLE_BITS];

   always_comb begin
      priority if (tag_c.centre) begin
         angle_c = HALF_ANGLE;
      end else if (angle_raw == '0) begin
         angle_c = MIN_ANGLE;
      end else begin
         angle_c = angle_raw;
      end
   end

   // angle times weight total
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
      end else begin
         valid_d_ff <= valid_c;
      end
   end

   always_ff @(posedge clock) begin
      at_d_ff  <= AT_W'(angle_c) * AT_W'(total_ff);
      tag_d_ff <= tag_c;
   end

   // slice, ring and outside classification
   always_comb begin
      red_in    = COLOR_ON;
      green_in  = COLOR_ON;
      blue_in   = COLOR_ON;
      region_in = REGION_OUTSIDE;
      priority if (tag_d_ff.in_disc) begin
         priority if ((weight_red_ff != '0) && (at_d_ff <= cut_r_ff)) begin
            region_in = REGION_RED;
            green_in  = COLOR_OFF;
            blue_in   = COLOR_OFF;
         end else if ((weight_green_ff != '0) && (at_d_ff > cut_r_ff)
                      && (at_d_ff <= cut_g_ff)) begin
            region_in = REGION_GREEN;
            red_in    = COLOR_OFF;
            blue_in   = COLOR_OFF;
         end else if ((weight_blue_ff != '0) && (at_d_ff > cut_g_ff)) begin
            region_in = REGION_BLUE;
            red_in    = COLOR_OFF;
            green_in  = COLOR_OFF;
         end else begin
            region_in = REGION_BLANK;
         end
      end else if (tag_d_ff.in_ring) begin
         region_in = REGION_BORDER;
         red_in    = COLOR_OFF;
         green_in  = COLOR_OFF;
         blue_in   = COLOR_OFF;
      end else begin
         region_in = REGION_OUTSIDE;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      red_ff     <= red_in;
      green_ff   <= green_in;
      blue_ff    <= blue_in;
      region_ff  <= region_in;
      invalid_ff <= (total_ff == '0);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = red_ff;
   assign rsp_out_green = green_ff;
   assign rsp_out_blue  = blue_ff;
   assign rsp_region    = region_ff;
   assign rsp_invalid   = invalid_ff;

endmodule

// File: design/pcpc_cordic.sv
// vectoring cordic pipeline, one micro-rotation per register stage
// depends on pcpc_pkg for widths, the arctangent table and the tag struct
module pcpc_cordic import pcpc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [VEC_W-1:0] in_x,
   input  logic signed [VEC_W-1:0] in_y,
   input  logic [TURN_W-1:0]       in_z,
   input  pcpc_tag_type            in_tag,
   output logic                    out_valid,
   output logic [TURN_W-1:0]       out_z,
   output pcpc_tag_type            out_tag
);

   logic                    valid_ff [CORDIC_STEPS];
   logic signed [VEC_W-1:0] x_ff     [CORDIC_STEPS];
   logic signed [VEC_W-1:0] y_ff     [CORDIC_STEPS];
   logic [TURN_W-1:0]       z_ff     [CORDIC_STEPS];
   pcpc_tag_type            tag_ff   [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic                    valid_cur;
      logic signed [VEC_W-1:0] x_cur, y_cur, x_in, y_in;
      logic [TURN_W-1:0]       z_cur, z_in;
      pcpc_tag_type            tag_cur;

      // stage input: ports for the first step, previous stage otherwise
      if (i == 0) begin : g_first
         assign valid_cur = in_valid;
         assign x_cur     = in_x;
         assign y_cur     = in_y;
         assign z_cur     = in_z;
         assign tag_cur   = in_tag;
      end else begin : g_next
         assign valid_cur = valid_ff[i-1];
         assign x_cur     = x_ff[i-1];
         assign y_cur     = y_ff[i-1];
         assign z_cur     = z_ff[i-1];
         assign tag_cur   = tag_ff[i-1];
      end

      // rotate toward the x axis, floor shifts
      always_comb begin
         if (!y_cur[VEC_W-1]) begin
            x_in = x_cur + (y_cur >>> i);
            y_in = y_cur - (x_cur >>> i);
            z_in = z_cur + ATAN_TURN[i];
         end else begin
            x_in = x_cur - (y_cur >>> i);
            y_in = y_cur + (x_cur >>> i);
            z_in = z_cur - ATAN_TURN[i];
         end
      end

      // stage valid
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_cur;
         end
      end

      // stage payload
      always_ff @(posedge clock) begin
         x_ff[i]   <= x_in;
         y_ff[i]   <= y_in;
         z_ff[i]   <= z_in;
         tag_ff[i] <= tag_cur;
      end
   end

   assign out_valid = valid_ff[CORDIC_STEPS-1];
   assign out_z     = z_ff[CORDIC_STEPS-1];
   assign out_tag   = tag_ff[CORDIC_STEPS-1];

endmodule

// File: design/pcpc_checker.sv
// port-level checks of the pie chart pixel classifier, bound to the core
// depends on pcpc_pkg for the latency and region codes
module pcpc_checker import pcpc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [COLOR_W-1:0]  rsp_out_red,
   input logic [COLOR_W-1:0]  rsp_out_green,
   input logic [COLOR_W-1:0]  rsp_out_blue,
   input logic [REGION_W-1:0] rsp_region,
   input logic                rsp_invalid
);

   localparam int CNT_W = $clog2(LATENCY + 1);

   logic [CNT_W-1:0] settle_ff;
   logic             settled;
   logic             colors_ok;

   // cycles since reset, so the latency check sees a full pipeline history
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= '0;
      end else if (settle_ff != CNT_W'(LATENCY)) begin
         settle_ff <= settle_ff + CNT_W'(1);
      end
   end

   assign settled = (settle_ff == CNT_W'(LATENCY));

   // expected colors for each region
   assign colors_ok =
      ((rsp_region == REGION_RED) && (rsp_out_red == COLOR_ON)
         && (rsp_out_green == COLOR_OFF) && (rsp_out_blue == COLOR_OFF))
      || ((rsp_region == REGION_GREEN) && (rsp_out_red == COLOR_OFF)
         && (rsp_out_green == COLOR_ON) && (rsp_out_blue == COLOR_OFF))
      || ((rsp_region == REGION_BLUE) && (rsp_out_red == COLOR_OFF)
         && (rsp_out_green == COLOR_OFF) && (rsp_out_blue == COLOR_ON))
      || ((rsp_region == REGION_BORDER) && (rsp_out_red == COLOR_OFF)
         && (rsp_out_green == COLOR_OFF) && (rsp_out_blue == COLOR_OFF))
      || (((rsp_region == REGION_BLANK) || (rsp_region == REGION_OUTSIDE))
         && (rsp_out_red == COLOR_ON) && (rsp_out_green == COLOR_ON)
         && (rsp_out_blue == COLOR_ON));

   // one result for every request transfer, a fixed latency later
   a_latency: assert property (@(posedge clock) disable iff (reset)
      settled |-> (rsp_valid == $past(start && !busy, LATENCY)))
      else $error("result strobe does not match request transfer");

   // colors agree with the reported region
   a_colors: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> colors_ok)
      else $error("result colors disagree with region");

   // with all weights zero no pixel lands in a slice
   a_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |->
         ((rsp_region != REGION_RED) && (rsp_region != REGION_GREEN)
          && (rsp_region != REGION_BLUE)))
      else $error("slice reported with all weights zero");

endmodule

bind pie_chart_pixel_classifier_core pcpc_checker u_pcpc_checker (.*);
